### rtl/csiu_pkg.sv
package csiu_pkg;

    localparam int BODY_CAPACITY = 64;
    localparam int BODY_LEN_W    = $clog2(BODY_CAPACITY + 1);
    localparam int KEY_W         = 31;
    localparam int BYTE_W        = 8;
    localparam int ACC_EXT_W     = KEY_W + 4;

    localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h1b;
    localparam logic [BYTE_W-1:0] BYTE_LBRACK  = 8'h5b;
    localparam logic [BYTE_W-1:0] BYTE_U       = 8'h75;
    localparam logic [BYTE_W-1:0] BYTE_C       = 8'h63;
    localparam logic [BYTE_W-1:0] BYTE_SEMI    = 8'h3b;
    localparam logic [BYTE_W-1:0] BYTE_COLON   = 8'h3a;
    localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] FINAL_LO     = 8'h40;
    localparam logic [BYTE_W-1:0] FINAL_HI     = 8'h7e;
    localparam logic [KEY_W-1:0]  KEY_CTRL_C   = 31'd3;

    localparam logic [1:0] FIELD_KEY  = 2'd0;
    localparam logic [1:0] FIELD_MODS = 2'd1;
    localparam logic [1:0] FIELD_TYPE = 2'd2;

    localparam logic [KEY_W-1:0] TYPE_PRESS   = 31'd1;
    localparam logic [KEY_W-1:0] TYPE_RELEASE = 31'd3;

    typedef enum logic [1:0] {
        ACT_TAP  = 2'd0,
        ACT_QUIT = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_UP   = 2'd3
    } t_action;

    typedef struct packed {
        t_action           action;
        logic [KEY_W-1:0]  key_code;
    } t_result;

endpackage

### rtl/csiu_in_stage.sv
module csiu_in_stage
    import csiu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_advance,
    output logic              o_in_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_in_stall = r_valid && !i_advance;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_in_byte;
        end
    end

endmodule

### rtl/csiu_parser.sv
module csiu_parser
    import csiu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_enhanced,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_CSI   = 2'd2,
        MODE_DROP  = 2'd3
    } t_mode;

    t_mode                 r_mode,  n_mode;
    logic [BODY_LEN_W-1:0] r_len,   n_len;
    logic [1:0]            r_field, n_field;
    logic                  r_digit, n_digit;
    logic [KEY_W-1:0]      r_acc,   n_acc;
    logic [KEY_W-1:0]      r_key,   n_key;
    logic [KEY_W-1:0]      r_mods,  n_mods;
    logic                  r_bad,   n_bad;

    logic                  clr;
    logic                  is_final;
    logic                  is_digit;
    logic [ACC_EXT_W-1:0]  acc_next;
    logic [KEY_W-1:0]      sel_key;
    logic [KEY_W-1:0]      sel_mods;
    logic [KEY_W-1:0]      sel_type;
    logic [KEY_W-1:0]      mods_m1;
    logic                  seq_ok;

    assign is_final = (i_byte >= FINAL_LO) && (i_byte <= FINAL_HI);
    assign is_digit = (i_byte >= BYTE_ZERO) && (i_byte <= BYTE_NINE);
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + ACC_EXT_W'(i_byte - BYTE_ZERO);

    always_comb begin
        sel_key  = r_key;
        sel_mods = r_mods;
        sel_type = TYPE_PRESS;
        case (r_field)
            FIELD_KEY:  sel_key  = r_acc;
            FIELD_MODS: sel_mods = r_acc;
            default:    sel_type = r_acc;
        endcase
    end

    assign mods_m1 = sel_mods - KEY_W'(1);
    assign seq_ok  = i_enhanced && (i_byte == BYTE_U) && !r_bad && r_digit;

    always_comb begin
        n_mode      = r_mode;
        n_len       = r_len;
        n_field     = r_field;
        n_digit     = r_digit;
        n_acc       = r_acc;
        n_key       = r_key;
        n_mods      = r_mods;
        n_bad       = r_bad;
        clr         = 1'b0;
        o_res_valid = 1'b0;
        o_res.action   = ACT_TAP;
        o_res.key_code = KEY_W'(i_byte);

        unique case (r_mode)
            MODE_PLAIN: begin
                if (i_byte == BYTE_ESC) begin
                    n_mode = MODE_ESC;
                end else if (!i_enhanced) begin
                    o_res_valid = 1'b1;
                end
            end
            MODE_ESC: begin
                n_mode = (i_byte == BYTE_LBRACK) ? MODE_CSI : MODE_PLAIN;
                clr    = 1'b1;
            end
            MODE_DROP: begin
                if (is_final) begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_CSI: begin
                if (r_len >= BODY_LEN_W'(BODY_CAPACITY)) begin
                    n_mode = MODE_DROP;
                    clr    = 1'b1;
                end else begin
                    n_len = r_len + BODY_LEN_W'(1);
                    if (!is_final) begin
                        if (!r_bad) begin
                            if (is_digit) begin
                                if (acc_next[ACC_EXT_W-1:KEY_W] != '0) begin
                                    n_bad = 1'b1;
                                end else begin
                                    n_acc   = acc_next[KEY_W-1:0];
                                    n_digit = 1'b1;
                                end
                            end else if (i_byte == BYTE_SEMI && r_field == FIELD_KEY
                                         && r_digit) begin
                                n_key   = r_acc;
                                n_field = FIELD_MODS;
                                n_acc   = '0;
                                n_digit = 1'b0;
                            end else if (i_byte == BYTE_COLON && r_field == FIELD_MODS
                                         && r_digit) begin
                                n_mods  = r_acc;
                                n_field = FIELD_TYPE;
                                n_acc   = '0;
                                n_digit = 1'b0;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                    end else begin
                        n_mode = MODE_PLAIN;
                        clr    = 1'b1;
                        o_res.key_code = sel_key;
                        if (seq_ok && (sel_type == TYPE_PRESS || sel_type == TYPE_RELEASE)) begin
                            o_res_valid = 1'b1;
                            if (sel_type == TYPE_PRESS && (sel_key == KEY_CTRL_C
                                || (sel_key == KEY_W'(BYTE_C) && mods_m1[2]))) begin
                                o_res.action = ACT_QUIT;
                            end else if (sel_type == TYPE_RELEASE) begin
                                o_res.action = ACT_UP;
                            end else begin
                                o_res.action = ACT_DOWN;
                            end
                        end
                    end
                end
            end
        endcase

        if (clr) begin
            n_len   = '0;
            n_field = FIELD_KEY;
            n_digit = 1'b0;
            n_acc   = '0;
            n_key   = '0;
            n_mods  = KEY_W'(1);
            n_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_len   <= '0;
            r_field <= FIELD_KEY;
            r_digit <= 1'b0;
            r_acc   <= '0;
            r_key   <= '0;
            r_mods  <= KEY_W'(1);
            r_bad   <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_field <= n_field;
            r_digit <= n_digit;
            r_acc   <= n_acc;
            r_key   <= n_key;
            r_mods  <= n_mods;
            r_bad   <= n_bad;
        end
    end

endmodule

### rtl/csiu_out_stage.sv
module csiu_out_stage
    import csiu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_out_stall,
    output logic    o_advance,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance   = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_step && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/csi_u_key_event_decoder_core.sv
// Decodes key events from a stream of terminal input bytes.
// The input channel (i_in_valid, i_in_byte, o_in_stall) takes one byte per
// transaction. The output channel (o_out_valid, o_action, o_key_code,
// i_out_stall) delivers zero or one event per byte.
// The single register is written through i_cfg_we and i_cfg_wdata; a one
// selects CSI u decoding, a zero turns plain bytes into taps.
// Throughput is one byte per cycle while the receiver does not stall. A
// byte is held in the input register, is decoded in a single pass against
// the parser state, and its event is written into the output register,
// where it stays visible until the receiver takes it.
// Synchronous reset clears the register to plain mode, empties both
// pipeline registers and returns the parser to its idle plain state.
// When the receiver stalls, the output event holds. The input register
// still fills, and o_in_stall rises once it holds a byte that cannot move
// forward, so no transaction is lost.
module csi_u_key_event_decoder_core
    import csiu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output logic [1:0]        o_action,
    output logic [KEY_W-1:0]  o_key_code,
    input  logic              i_out_stall
);

    logic              r_enhanced;
    logic              advance;
    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    logic              step;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enhanced <= 1'b0;
        end else if (i_cfg_we) begin
            r_enhanced <= i_cfg_wdata;
        end
    end

    csiu_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_advance  (advance),
        .o_in_stall (o_in_stall),
        .o_valid    (stage_valid),
        .o_byte     (stage_byte)
    );

    assign step = stage_valid && advance;

    csiu_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enhanced  (r_enhanced),
        .i_step      (step),
        .i_byte      (stage_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    csiu_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_action   = out_res.action;
    assign o_key_code = out_res.key_code;

endmodule

### rtl/csiu_checker.sv
module csiu_checker
    import csiu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic [BYTE_W-1:0] i_in_byte,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic [1:0]        o_action,
    input logic [KEY_W-1:0]  o_key_code,
    input logic              i_out_stall
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_action) && $stable(o_key_code))
        else $error("Stalled output transaction changed.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_byte))
        else $error("Stalled input transaction changed.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Pipeline not empty after reset.");

    a_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_TAP |-> o_key_code[KEY_W-1:BYTE_W] == '0)
        else $error("Tap carries a value wider than a byte.");

    a_quit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == ACT_QUIT |->
            o_key_code == KEY_CTRL_C || o_key_code == KEY_W'(BYTE_C))
        else $error("Quit event with an unexpected key code.");

endmodule

bind csi_u_key_event_decoder_core csiu_checker u_checker (.*);
